FILE: hw/rtl/stjq_pkg.sv
// shared types and constants for the sorted timer job queue
package stjq_pkg;

  localparam int unsigned Entries    = 16;
  localparam int unsigned TimeBits   = 48;
  localparam int unsigned RepeatBits = 32;
  localparam int unsigned HandleBits = $clog2(Entries);
  localparam int unsigned CountBits  = $clog2(Entries + 1);

  typedef logic [2:0] cmd_t;
  localparam cmd_t CmdSchedAbs = 3'd0;
  localparam cmd_t CmdSchedRel = 3'd1;
  localparam cmd_t CmdCancel   = 3'd2;
  localparam cmd_t CmdPoll     = 3'd3;
  localparam cmd_t CmdReport   = 3'd4;

  typedef logic [2:0] status_t;
  localparam status_t StAccepted = 3'd0;
  localparam status_t StFull     = 3'd1;
  localparam status_t StNotFound = 3'd2;
  localparam status_t StNoneDue  = 3'd3;
  localparam status_t StDispatch = 3'd4;
  localparam status_t StHalted   = 3'd5;
  localparam status_t StBadSeq   = 3'd6;

  typedef logic [1:0] outcome_t;
  localparam outcome_t OcOk   = 2'd0;
  localparam outcome_t OcDone = 2'd1;
  localparam outcome_t OcFail = 2'd2;

  // chain operation broadcast to every cell
  typedef enum logic [1:0] {
    OpHold   = 2'd0,
    OpInsert = 2'd1,
    OpRemove = 2'd2
  } chain_op_e;

  typedef struct packed {
    chain_op_e                 op;
    logic [TimeBits-1:0]       due;
    logic [RepeatBits-1:0]     rep;
    logic [HandleBits-1:0]     hdl;
  } chain_cmd_t;

  typedef struct packed {
    logic                      valid;
    logic [HandleBits-1:0]     hdl;
    logic [TimeBits-1:0]       due;
    logic [RepeatBits-1:0]     rep;
  } slot_t;

endpackage

FILE: hw/rtl/stjq_cell.sv
// one queue cell: holds a job and shifts with its neighbours on insert or removal
module stjq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stjq_pkg::chain_cmd_t cmd_i,
  input  stjq_pkg::slot_t    prev_i,
  input  logic               prev_ins_i,
  input  stjq_pkg::slot_t    next_i,
  input  logic               prev_rm_i,
  output logic               ins_o,
  output logic               rm_o,
  output stjq_pkg::slot_t    slot_o
);
  import stjq_pkg::*;

  slot_t slot_q, slot_d;
  logic  here_ins, here_rm;

  // insert point: empty or later than new job
  assign here_ins = !slot_q.valid || (slot_q.due > cmd_i.due);
  assign ins_o    = prev_ins_i || here_ins;
  assign here_rm  = slot_q.valid && (slot_q.hdl == cmd_i.hdl);
  assign rm_o     = prev_rm_i || here_rm;

  // next content
  always_comb begin
    slot_d = slot_q;
    case (cmd_i.op)
      OpInsert: begin
        if (prev_ins_i) slot_d = prev_i;
        else if (here_ins) begin
          slot_d.valid = 1'b1;
          slot_d.hdl   = cmd_i.hdl;
          slot_d.due   = cmd_i.due;
          slot_d.rep   = cmd_i.rep;
        end
      end
      OpRemove: begin
        if (rm_o) slot_d = next_i;
      end
      default: slot_d = slot_q;
    endcase
  end

  // valid bit under reset, payload free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q.valid <= 1'b0;
    end else begin
      slot_q.valid <= slot_d.valid;
      slot_q.hdl   <= slot_d.hdl;
      slot_q.due   <= slot_d.due;
      slot_q.rep   <= slot_d.rep;
    end
  end

  assign slot_o = slot_q;
endmodule

FILE: hw/rtl/sorted_timer_job_queue_unit.sv
// top level of the sorted timer job queue: control and chain of cells
//
//  channel | signals                                         | dir
//  in      | in_valid_i/in_ready_o, command..outcome          | in
//  out     | out_valid_o/out_ready_i, status..pending_count   | out
//
// each item is decided and its result latched, then the cell chain shifts;
// for a repeating job re-queued on an ok outcome the chain first removes it,
// then inserts it in sorted order. the result is offered once the
// chain has settled and the next item waits until it has been taken.
// reset empties the chain and clears all flags. the output register holds
// its result until taken.
module sorted_timer_job_queue_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     command_i,
  input  logic [stjq_pkg::TimeBits-1:0]  time_value_i,
  input  logic [stjq_pkg::RepeatBits-1:0] repeat_interval_i,
  input  logic [stjq_pkg::TimeBits-1:0]  now_i,
  input  logic [3:0]                     handle_i,
  input  logic [1:0]                     outcome_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     status_o,
  output logic [3:0]                     job_handle_o,
  output logic [47:0]                    due_time_o,
  output logic [4:0]                     pending_count_o
);
  import stjq_pkg::*;

  localparam logic [TimeBits-1:0] TimeMax = '1;

  slot_t           slots [Entries];
  logic [Entries:0] ins_c, rm_c;
  chain_cmd_t      ccmd_q, ccmd_d;
  logic            busy_q;
  logic [Entries-1:0] in_use_q, in_use_d;
  logic [CountBits-1:0] count_q, count_d;
  logic            await_q, await_d, halt_q, halt_d;
  logic [HandleBits-1:0] disp_q, disp_d;
  logic            ovalid_q;
  status_t         ost_q, ost_d;
  logic [HandleBits-1:0] oh_q, oh_d;
  logic [TimeBits-1:0] odue_q, odue_d;
  logic            take;

  // chain of cells
  assign ins_c[0] = 1'b0;
  assign rm_c[0]  = 1'b0;
  for (genvar g = 0; g < Entries; g++) begin : g_cell
    slot_t prv, nxt;
    if (g == 0) begin : g_first
      assign prv = '0;
    end else begin : g_mid
      assign prv = slots[g-1];
    end
    if (g == Entries - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_inner
      assign nxt = slots[g+1];
    end
    stjq_cell u_cell (
      .clk_i, .rst_ni, .cmd_i(ccmd_q), .prev_i(prv), .prev_ins_i(ins_c[g]),
      .next_i(nxt), .prev_rm_i(rm_c[g]), .ins_o(ins_c[g+1]), .rm_o(rm_c[g+1]),
      .slot_o(slots[g])
    );
  end

  assign in_ready_o = !busy_q && !ovalid_q;
  assign take       = in_valid_i && in_ready_o;

  // lookup helpers over the cells
  logic [HandleBits-1:0] free_h;
  logic                  free_ok;
  logic                  disp_found;
  logic [TimeBits-1:0]   disp_due;
  logic [RepeatBits-1:0] disp_rep;
  logic                  can_found;
  logic [TimeBits-1:0]   can_due;
  logic [TimeBits:0]     rel_sum, rep_sum;
  logic [TimeBits-1:0]   sched_due, req_due;

  always_comb begin
    free_h = '0;
    free_ok = 1'b0;
    for (int k = Entries - 1; k >= 0; k--) begin
      if (!in_use_q[k]) begin
        free_h  = HandleBits'(k);
        free_ok = 1'b1;
      end
    end
    disp_found = 1'b0; disp_due = '0; disp_rep = '0;
    can_found = 1'b0; can_due = '0;
    for (int k = 0; k < Entries; k++) begin
      if (slots[k].valid && slots[k].hdl == disp_q) begin
        disp_found = 1'b1; disp_due = slots[k].due; disp_rep = slots[k].rep;
      end
      if (slots[k].valid && slots[k].hdl == handle_i[HandleBits-1:0]) begin
        can_found = 1'b1; can_due = slots[k].due;
      end
    end
  end

  assign rel_sum   = {1'b0, now_i} + {1'b0, time_value_i};
  assign sched_due = (command_i == CmdSchedRel)
                     ? (rel_sum[TimeBits] ? TimeMax : rel_sum[TimeBits-1:0]) : time_value_i;
  assign rep_sum   = {1'b0, disp_due} + {{(TimeBits-RepeatBits+1){1'b0}}, disp_rep};
  assign req_due   = rep_sum[TimeBits] ? TimeMax : rep_sum[TimeBits-1:0];

  // command decode
  always_comb begin
    ccmd_d   = '{op: OpHold, due: '0, rep: '0, hdl: '0};
    in_use_d = in_use_q; count_d = count_q;
    await_d = await_q; halt_d = halt_q; disp_d = disp_q;
    ost_d = StBadSeq; oh_d = '0; odue_d = '0;
    case (command_i)
      CmdSchedAbs, CmdSchedRel: begin
        if (!free_ok || count_q >= CountBits'(Entries)) begin
          ost_d = StFull;
        end else begin
          ost_d = StAccepted; oh_d = free_h; odue_d = sched_due;
          in_use_d[free_h] = 1'b1;
          count_d = count_q + 1'b1;
          ccmd_d = '{op: OpInsert, due: sched_due, rep: repeat_interval_i, hdl: free_h};
        end
      end
      CmdCancel: begin
        if (await_q && handle_i[HandleBits-1:0] == disp_q) begin
          ost_d = StBadSeq;
        end else if (!in_use_q[handle_i[HandleBits-1:0]] || !can_found) begin
          ost_d = StNotFound;
        end else begin
          ost_d = StAccepted; oh_d = handle_i[HandleBits-1:0]; odue_d = can_due;
          in_use_d[handle_i[HandleBits-1:0]] = 1'b0;
          count_d = count_q - 1'b1;
          if (halt_q && handle_i[HandleBits-1:0] == disp_q) halt_d = 1'b0;
          ccmd_d = '{op: OpRemove, due: '0, rep: '0, hdl: handle_i[HandleBits-1:0]};
        end
      end
      CmdPoll: begin
        if (await_q) begin
          ost_d = StBadSeq;
        end else if (halt_q) begin
          ost_d = StHalted; oh_d = disp_q;
          odue_d = disp_found ? disp_due : '0;
        end else if (!slots[0].valid || slots[0].due > now_i) begin
          ost_d = StNoneDue;
        end else begin
          ost_d = StDispatch; oh_d = slots[0].hdl; odue_d = slots[0].due;
          disp_d = slots[0].hdl; await_d = 1'b1;
        end
      end
      CmdReport: begin
        if (!await_q || !disp_found || outcome_i == 2'd3) begin
          ost_d = StBadSeq;
        end else begin
          oh_d = disp_q; await_d = 1'b0;
          if (outcome_i == OcFail) begin
            halt_d = 1'b1; ost_d = StHalted; odue_d = disp_due;
          end else if (outcome_i == OcDone || disp_rep == '0) begin
            ost_d = StAccepted; odue_d = disp_due;
            in_use_d[disp_q] = 1'b0; count_d = count_q - 1'b1;
            ccmd_d = '{op: OpRemove, due: '0, rep: '0, hdl: disp_q};
          end else begin
            // remove now, re-insert in the following cycle
            ost_d = StAccepted; odue_d = req_due;
            ccmd_d = '{op: OpRemove, due: req_due, rep: disp_rep, hdl: disp_q};
          end
        end
      end
      default: ost_d = StBadSeq;
    endcase
  end

  logic requeue_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; in_use_q <= '0; count_q <= '0; await_q <= 1'b0;
      halt_q <= 1'b0; disp_q <= '0; ovalid_q <= 1'b0; requeue_q <= 1'b0;
      ccmd_q <= '{op: OpHold, due: '0, rep: '0, hdl: '0};
    end else begin
      if (take) begin
        busy_q <= 1'b1; in_use_q <= in_use_d; count_q <= count_d;
        await_q <= await_d; halt_q <= halt_d; disp_q <= disp_d;
        ovalid_q <= 1'b1; ccmd_q <= ccmd_d;
        requeue_q <= (command_i == CmdReport) && (ccmd_d.op == OpRemove)
                     && (ccmd_d.rep != '0) && (ost_d == StAccepted)
                     && (outcome_i == OcOk);
      end else if (requeue_q) begin
        requeue_q <= 1'b0;
        ccmd_q.op <= OpInsert;
      end else begin
        busy_q <= 1'b0;
        ccmd_q.op <= OpHold;
      end
      // result leaves only on an output transfer
      if (out_valid_o && out_ready_i) ovalid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      ost_q <= ost_d; oh_q <= oh_d; odue_q <= odue_d;
    end
  end

  assign out_valid_o     = ovalid_q && !busy_q;
  assign status_o        = ost_q;
  assign job_handle_o    = oh_q;
  assign due_time_o      = odue_q;
  assign pending_count_o = count_q;
endmodule

FILE: bench/tb.sv
// self-checking bench for the sorted timer job queue unit
`timescale 1ns / 100ps

module tb;
  import stjq_pkg::*;

  typedef struct packed {
    cmd_t                  cmd;
    logic [TimeBits-1:0]   tval;
    logic [RepeatBits-1:0] rep;
    logic [TimeBits-1:0]   now;
    logic [3:0]            hdl;
    outcome_t              oc;
  } job_req_t;

  typedef struct packed {
    status_t             status;
    logic [3:0]          hdl;
    logic [TimeBits-1:0] due;
    logic [4:0]          count;
  } job_rsp_t;

  localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  job_req_t req;
  logic [2:0] status;
  logic [3:0] job_handle;
  logic [47:0] due_time;
  logic [4:0] pending_count;

  // shadow of the job queue
  logic [3:0]            q_hdl [Entries];
  logic [TimeBits-1:0]   q_due [Entries];
  logic [RepeatBits-1:0] q_rep [Entries];
  int unsigned           q_len;
  logic [Entries-1:0]    in_use;
  logic                  awaiting, halted;
  logic [3:0]            disp_hdl;

  job_req_t pending_reqs[$];
  job_rsp_t expected_rsps[$];
  int  n_errors;
  int  hold_off;
  bit  pausing;

  sorted_timer_job_queue_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(req.cmd), .time_value_i(req.tval), .repeat_interval_i(req.rep),
    .now_i(req.now), .handle_i(req.hdl), .outcome_i(req.oc),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .job_handle_o(job_handle), .due_time_o(due_time),
    .pending_count_o(pending_count)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [TimeBits-1:0] sat_sum(logic [TimeBits-1:0] a,
                                                  logic [TimeBits-1:0] b);
    logic [TimeBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeBits] ? TimeMax : s[TimeBits-1:0];
  endfunction

  // sorted insert after every job due at or before the new one
  function automatic void queue_insert(logic [3:0] h, logic [TimeBits-1:0] d,
                                       logic [RepeatBits-1:0] r);
    int pos;
    pos = 0;
    while (pos < q_len && q_due[pos] <= d) pos++;
    for (int i = q_len; i > pos; i--) begin
      q_hdl[i] = q_hdl[i-1]; q_due[i] = q_due[i-1]; q_rep[i] = q_rep[i-1];
    end
    q_hdl[pos] = h; q_due[pos] = d; q_rep[pos] = r;
    q_len++;
  endfunction

  function automatic void queue_remove(int pos);
    for (int i = pos; i < q_len - 1; i++) begin
      q_hdl[i] = q_hdl[i+1]; q_due[i] = q_due[i+1]; q_rep[i] = q_rep[i+1];
    end
    q_len--;
  endfunction

  function automatic int queue_find(logic [3:0] h);
    for (int i = 0; i < q_len; i++) if (q_hdl[i] == h) return i;
    return -1;
  endfunction

  // next result of the job queue for one command
  function automatic job_rsp_t job_queue_step(job_req_t r);
    job_rsp_t o;
    int p, k;
    logic [TimeBits-1:0] d;
    logic [RepeatBits-1:0] rr;
    o = '0;
    o.status = StBadSeq;
    case (r.cmd)
      CmdSchedAbs, CmdSchedRel: begin
        d = (r.cmd == CmdSchedAbs) ? r.tval : sat_sum(r.now, r.tval);
        k = 0;
        while (k < Entries && in_use[k]) k++;
        if (q_len >= Entries || k >= Entries) o.status = StFull;
        else begin
          in_use[k] = 1'b1;
          queue_insert(4'(k), d, r.rep);
          o.status = StAccepted; o.hdl = 4'(k); o.due = d;
        end
      end
      CmdCancel: begin
        if (!(awaiting && r.hdl == disp_hdl)) begin
          p = in_use[r.hdl] ? queue_find(r.hdl) : -1;
          if (p < 0) o.status = StNotFound;
          else begin
            o.due = q_due[p]; o.hdl = r.hdl;
            queue_remove(p);
            in_use[r.hdl] = 1'b0;
            if (halted && r.hdl == disp_hdl) halted = 1'b0;
            o.status = StAccepted;
          end
        end
      end
      CmdPoll: begin
        if (awaiting) o.status = StBadSeq;
        else if (halted) begin
          o.status = StHalted; o.hdl = disp_hdl;
          p = queue_find(disp_hdl);
          if (p >= 0) o.due = q_due[p];
        end else if (q_len == 0 || q_due[0] > r.now) o.status = StNoneDue;
        else begin
          o.status = StDispatch; o.hdl = q_hdl[0]; o.due = q_due[0];
          disp_hdl = q_hdl[0]; awaiting = 1'b1;
        end
      end
      CmdReport: begin
        p = awaiting ? queue_find(disp_hdl) : -1;
        if (p >= 0 && r.oc != 2'd3) begin
          d = q_due[p];
          o.hdl = disp_hdl;
          awaiting = 1'b0;
          o.status = (r.oc == OcFail) ? StHalted : StAccepted;
          if (r.oc == OcFail) begin
            halted = 1'b1; o.due = d;
          end else if (r.oc == OcDone || q_rep[p] == '0) begin
            queue_remove(p); in_use[disp_hdl] = 1'b0; o.due = d;
          end else begin
            rr = q_rep[p];
            queue_remove(p);
            d = sat_sum(d, {{(TimeBits-RepeatBits){1'b0}}, rr});
            queue_insert(disp_hdl, d, rr);
            o.due = d;
          end
        end
      end
      default: ;
    endcase
    o.count = 5'(q_len);
    return o;
  endfunction

  function automatic job_req_t mk(cmd_t c, logic [TimeBits-1:0] t,
                                  logic [RepeatBits-1:0] r, logic [TimeBits-1:0] n,
                                  logic [3:0] h, outcome_t o);
    job_req_t x;
    x.cmd = c; x.tval = t; x.rep = r; x.now = n; x.hdl = h; x.oc = o;
    return x;
  endfunction

  function automatic logic [TimeBits-1:0] rnd_time();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom} & TimeMax;
      1: return TimeMax - $urandom_range(0, 20);
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  function automatic job_req_t rnd_req();
    job_req_t x;
    int sel;
    x = '0;
    x.tval = rnd_time(); x.now = rnd_time();
    x.rep = ($urandom_range(0, 2) == 0) ? 32'd0
          : (($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 300));
    x.hdl = $urandom_range(0, 15);
    x.oc = ($urandom_range(0, 15) == 0) ? 2'd3
         : (($urandom_range(0, 7) == 0) ? OcFail : outcome_t'($urandom_range(0, 1)));
    sel = $urandom_range(0, 99);
    if (sel < 22) x.cmd = CmdSchedAbs;
    else if (sel < 40) x.cmd = CmdSchedRel;
    else if (sel < 55) x.cmd = CmdCancel;
    else if (sel < 77) x.cmd = CmdPoll;
    else if (sel < 97) x.cmd = CmdReport;
    else x.cmd = cmd_t'($urandom_range(5, 7));
    return x;
  endfunction

  // stimulus
  initial begin
    job_req_t x;
    n_errors = 0; pausing = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    pending_reqs.push_back(mk(CmdPoll, 0, 0, TimeMax, 0, OcOk));
    pending_reqs.push_back(mk(CmdReport, 0, 0, 0, 0, OcOk));
    pending_reqs.push_back(mk(CmdCancel, 0, 0, 0, 15, OcOk));
    pending_reqs.push_back(mk(CmdSchedAbs, TimeMax, '1, 0, 0, OcOk));
    pending_reqs.push_back(mk(CmdSchedRel, 100, 0, TimeMax - 5, 0, OcOk));
    pending_reqs.push_back(mk(CmdSchedAbs, 5, 10, 0, 0, OcOk));
    pending_reqs.push_back(mk(CmdSchedAbs, 5, 0, 0, 0, OcOk));
    pending_reqs.push_back(mk(CmdPoll, 0, 0, 4, 0, OcOk));
    pending_reqs.push_back(mk(CmdPoll, 0, 0, 5, 0, OcOk));
    pending_reqs.push_back(mk(CmdPoll, 0, 0, 5, 0, OcOk));
    pending_reqs.push_back(mk(CmdCancel, 0, 0, 0, 2, OcOk));
    pending_reqs.push_back(mk(CmdReport, 0, 0, 0, 0, 2'd3));
    pending_reqs.push_back(mk(CmdReport, 0, 0, 0, 0, OcOk));
    pending_reqs.push_back(mk(CmdPoll, 0, 0, TimeMax, 0, OcOk));
    pending_reqs.push_back(mk(CmdReport, 0, 0, 0, 0, OcFail));
    pending_reqs.push_back(mk(CmdPoll, 0, 0, TimeMax, 0, OcOk));
    pending_reqs.push_back(mk(CmdSchedRel, 1, 3, 0, 0, OcOk));
    pending_reqs.push_back(mk(CmdCancel, 0, 0, 0, 3, OcOk));
    pending_reqs.push_back(mk(3'd7, '1, '1, '1, 15, 2'd3));
    pending_reqs.push_back(mk(3'd5, 0, 0, 0, 0, OcOk));
    for (int i = 0; i < 18; i++)
      pending_reqs.push_back(mk(CmdSchedAbs, TimeBits'(i), 0, 0, 0, OcOk));
    for (int i = 0; i < 1900; i++) begin
      if (i == 900) begin
        // drain fully before carrying on
        wait (pending_reqs.size() == 0 && !in_valid && expected_rsps.size() == 0);
        pausing = 1;
        repeat (4) @(posedge clk);
        pausing = 0;
      end
      x = rnd_req();
      pending_reqs.push_back(x);
    end
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_rsps.size() == 0);
    repeat (20) @(posedge clk);
    if (n_errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // driver: bursts with gaps
  int burst_left, gap_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0; req <= '0;
      burst_left <= 0; gap_left <= 0;
      q_len = 0; in_use = '0; awaiting = 0; halted = 0; disp_hdl = 0;
    end else begin
      if (in_valid && in_ready) expected_rsps.push_back(job_queue_step(req));
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || pausing || pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          in_valid <= 1'b1;
          req <= pending_reqs.pop_front();
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // monitor: own stall pattern, one long hold-off early on
  int rx_cnt;
  job_rsp_t want;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0; rx_cnt <= 0; hold_off <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("result with nothing expected"); n_errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (status !== want.status) begin
            $error("status exp %0d got %0d", want.status, status); n_errors++;
          end
          if (job_handle !== want.hdl) begin
            $error("job_handle exp %0d got %0d", want.hdl, job_handle); n_errors++;
          end
          if (due_time !== want.due) begin
            $error("due_time exp %0h got %0h", want.due, due_time); n_errors++;
          end
          if (pending_count !== want.count) begin
            $error("pending_count exp %0d got %0d", want.count, pending_count);
            n_errors++;
          end
        end
        rx_cnt <= rx_cnt + 1;
        if (rx_cnt == 300) hold_off <= 200;
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else if (rx_cnt > 1200 && rx_cnt < 1500) out_ready <= 1'b1;
      else out_ready <= (($urandom_range(0, 9) < 7) || (rx_cnt % 64 < 8));
    end
  end

endmodule
